// File: hdl/pprd_pkg.sv
package pprd_pkg;

  localparam int COORD_BITS     = 12;
  localparam int COMP_FRAC_BITS = 14;
  localparam int COMP_BITS      = COMP_FRAC_BITS + 2;
  localparam int VEC_BITS       = 3 * COMP_BITS;
  localparam int SCALE_BITS     = 16;
  localparam int RECIP_BITS     = 24;
  localparam int HEIGHT_BITS    = 13;
  localparam int JIT_BITS       = 8;
  localparam int CFG_IDX_BITS   = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SCALE_X      = 4'd0,
    CFG_SCALE_Y      = 4'd1,
    CFG_RECIP_WIDTH  = 4'd2,
    CFG_RECIP_HEIGHT = 4'd3,
    CFG_IMAGE_HEIGHT = 4'd4,
    CFG_RIGHT_VEC    = 4'd5,
    CFG_UP_VEC       = 4'd6,
    CFG_BACK_VEC     = 4'd7
  } cfg_reg_t;

  localparam logic [SCALE_BITS-1:0]  RST_SCALE  = SCALE_BITS'(8192);
  localparam logic [RECIP_BITS-1:0]  RST_RECIP  = RECIP_BITS'(16384);
  localparam logic [HEIGHT_BITS-1:0] RST_HEIGHT = HEIGHT_BITS'(1024);
  localparam logic [COMP_BITS-1:0]   ONE_COMP   = COMP_BITS'(1 << COMP_FRAC_BITS);
  localparam logic [COMP_BITS-1:0]   ZERO_COMP  = '0;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [JIT_BITS-1:0]   jitter_x;
    logic [JIT_BITS-1:0]   jitter_y;
  } pprd_in_t;

  typedef struct packed {
    logic signed [COMP_BITS-1:0] dir_x;
    logic signed [COMP_BITS-1:0] dir_y;
    logic signed [COMP_BITS-1:0] dir_z;
  } pprd_out_t;

endpackage

// File: hdl/pinhole_primary_ray_direction.sv
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | pixel_x, pixel_y, jitter_x, jitter_y
// out_    | output    | out_valid/out_stall| dir_x, dir_y, dir_z
// cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request per cycle while out_stall does not freeze the pipeline; 61 register
// stages. Depth is set by the square root (one result bit per stage, 31
// stages) and the three dividers (one quotient bit per stage, 15 stages) after
// 13 front stages, plus one dividend stage and the output register.
// rst_n (synchronous) empties the pipeline and loads the default camera setup.
// out_stall with out_valid high freezes the whole pipeline and raises in_stall.
module pinhole_primary_ray_direction (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  pprd_pkg::pprd_in_t                      in_data,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output pprd_pkg::pprd_out_t                     out_data,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [pprd_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [pprd_pkg::VEC_BITS-1:0]           cfg_data
);
  import pprd_pkg::*;

  localparam int PY_W = ((HEIGHT_BITS + JIT_BITS > COORD_BITS + JIT_BITS + 1) ?
                         HEIGHT_BITS + JIT_BITS : COORD_BITS + JIT_BITS + 1) + 1;
  localparam int RS_T     = 16;
  localparam int RS_A     = 12;
  localparam int P_W      = PY_W + RECIP_BITS + 1;
  localparam int T_W      = P_W + 1 - RS_T;
  localparam int AP_W     = T_W + SCALE_BITS + 1;
  localparam int A_W      = AP_W + 1 - RS_A;
  localparam int PR_W     = A_W + COMP_BITS;
  localparam int D_W      = PR_W + 2;
  localparam int NG       = (D_W + 7) / 8;
  localparam int POS_W    = $clog2(NG * 8);
  localparam int NORM_MSB = 2 * COMP_FRAC_BITS + 1;
  localparam int NM_W     = NORM_MSB + 1;
  localparam int SUM_W    = 2 * NM_W + 2;
  localparam int SQ_STEPS = SUM_W / 2;
  localparam int LEN_W    = SQ_STEPS;
  localparam int RM_W     = LEN_W + 2;
  localparam int QB       = COMP_FRAC_BITS + 1;
  localparam int N_W      = NM_W + COMP_FRAC_BITS + 1;
  localparam int NSTG     = 13 + SQ_STEPS + 1 + QB + 1;

  localparam logic [P_W:0] T_OFS =
    (P_W + 1)'((64'd1 << (RECIP_BITS + JIT_BITS - 1)) - (64'd1 << (RS_T - 1)));
  localparam logic [AP_W:0]  A_RND    = (AP_W + 1)'(64'd1 << (RS_A - 1));
  localparam logic [PY_W-1:0] HALF_PIX = PY_W'(1 << (JIT_BITS - 1));

  // configuration
  logic [SCALE_BITS-1:0]  scale_x_r, scale_y_r;
  logic [RECIP_BITS-1:0]  recip_w_r, recip_h_r;
  logic [HEIGHT_BITS-1:0] height_r;
  logic [VEC_BITS-1:0]    right_r, up_r, back_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r <= RST_SCALE;
      scale_y_r <= RST_SCALE;
      recip_w_r <= RST_RECIP;
      recip_h_r <= RST_RECIP;
      height_r  <= RST_HEIGHT;
      right_r   <= {ZERO_COMP, ZERO_COMP, ONE_COMP};
      up_r      <= {ZERO_COMP, ONE_COMP, ZERO_COMP};
      back_r    <= {ONE_COMP, ZERO_COMP, ZERO_COMP};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCALE_X:      scale_x_r <= cfg_data[SCALE_BITS-1:0];
        CFG_SCALE_Y:      scale_y_r <= cfg_data[SCALE_BITS-1:0];
        CFG_RECIP_WIDTH:  recip_w_r <= cfg_data[RECIP_BITS-1:0];
        CFG_RECIP_HEIGHT: recip_h_r <= cfg_data[RECIP_BITS-1:0];
        CFG_IMAGE_HEIGHT: height_r  <= cfg_data[HEIGHT_BITS-1:0];
        CFG_RIGHT_VEC:    right_r   <= cfg_data;
        CFG_UP_VEC:       up_r      <= cfg_data;
        CFG_BACK_VEC:     back_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: whole pipe advances unless the output is held
  logic            adv;
  logic [NSTG-1:0] vld_r;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // front stages
  logic signed [PY_W-1:0]  px_r, py_r;
  logic signed [P_W-1:0]   prx_r, pry_r;
  logic signed [T_W-1:0]   tx_r, ty_r;
  logic signed [AP_W-1:0]  apx_r, apy_r;
  logic signed [A_W-1:0]   a_r, b_r;
  logic signed [PR_W-1:0]  pr_r [3];
  logic signed [PR_W-1:0]  pu_r [3];
  logic signed [D_W-1:0]   d_r [3];
  logic [D_W-1:0]          mag8_r [3];
  logic [D_W-1:0]          mag9_r [3];
  logic [D_W-1:0]          mag10_r [3];
  logic [D_W-1:0]          or_r;
  logic [2:0]              neg8_r, neg9_r, neg10_r, neg11_r, neg12_r, neg13_r;
  logic [NG-1:0]           gnz_r;
  logic [2:0]              gpos_r [NG];
  logic [POS_W-1:0]        pos_r;
  logic                    zero10_r, zero11_r, zero12_r, zero13_r;
  logic [NM_W-1:0]         nm11_r [3];
  logic [NM_W-1:0]         nm12_r [3];
  logic [NM_W-1:0]         nm13_r [3];
  logic [2*NM_W-1:0]       sqv_r [3];
  logic [SUM_W-1:0]        sum_r;

  logic signed [PY_W-1:0]  px_nxt, py_nxt;
  logic signed [P_W:0]     txs_nxt, tys_nxt;
  logic signed [AP_W:0]    as_nxt, bs_nxt;
  logic signed [D_W-1:0]   d_nxt [3];
  logic [D_W-1:0]          mag_nxt [3];
  logic [2:0]              neg_nxt;
  logic [NG*8-1:0]         orp;
  logic [NG-1:0]           gnz_nxt;
  logic [2:0]              gpos_nxt [NG];
  logic [POS_W-1:0]        pos_nxt;
  logic [D_W-1:0]          shv;
  logic [NM_W-1:0]         nm_nxt [3];

  always_comb begin
    px_nxt = PY_W'({in_data.pixel_x, {JIT_BITS{1'b0}}}) + PY_W'(in_data.jitter_x) + HALF_PIX;
    py_nxt = PY_W'({height_r, {JIT_BITS{1'b0}}}) - HALF_PIX
             - PY_W'({in_data.pixel_y, {JIT_BITS{1'b0}}}) - PY_W'(in_data.jitter_y);
    // subtract 0.5 at Q.32 and round to Q.16
    txs_nxt = $signed({prx_r[P_W-1], prx_r}) - $signed(T_OFS);
    tys_nxt = $signed({pry_r[P_W-1], pry_r}) - $signed(T_OFS);
    as_nxt  = $signed({apx_r[AP_W-1], apx_r}) + $signed(A_RND);
    bs_nxt  = $signed({apy_r[AP_W-1], apy_r}) + $signed(A_RND);
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = D_W'(pr_r[i]) + D_W'(pu_r[i])
                 - {{(D_W - COMP_BITS - 16){back_r[i*COMP_BITS + COMP_BITS - 1]}},
                    back_r[i*COMP_BITS +: COMP_BITS], 16'h0000};
      neg_nxt[i] = d_r[i][D_W-1];
      mag_nxt[i] = neg_nxt[i] ? D_W'(-d_r[i]) : D_W'(d_r[i]);
    end
    // leading one: per-byte first, then across bytes
    orp = (NG*8)'(or_r);
    for (int g = 0; g < NG; g++) begin
      gnz_nxt[g]  = |orp[g*8 +: 8];
      gpos_nxt[g] = 3'd0;
      for (int k = 0; k < 8; k++) begin
        if (orp[g*8 + k]) gpos_nxt[g] = 3'(k);
      end
    end
    pos_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      if (gnz_r[g]) pos_nxt = POS_W'(g * 8) + POS_W'(gpos_r[g]);
    end
    shv = '0;
    for (int i = 0; i < 3; i++) begin
      if (pos_r >= POS_W'(NORM_MSB)) begin
        shv = mag10_r[i] >> (pos_r - POS_W'(NORM_MSB));
      end else begin
        shv = mag10_r[i] << (POS_W'(NORM_MSB) - pos_r);
      end
      nm_nxt[i] = shv[NM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      prx_r <= px_r * $signed({1'b0, recip_w_r});
      pry_r <= py_r * $signed({1'b0, recip_h_r});
      tx_r  <= txs_nxt[P_W:RS_T];
      ty_r  <= tys_nxt[P_W:RS_T];
      apx_r <= tx_r * $signed({1'b0, scale_x_r});
      apy_r <= ty_r * $signed({1'b0, scale_y_r});
      a_r   <= as_nxt[AP_W:RS_A];
      b_r   <= bs_nxt[AP_W:RS_A];
      for (int i = 0; i < 3; i++) begin
        pr_r[i]    <= a_r * $signed(right_r[i*COMP_BITS +: COMP_BITS]);
        pu_r[i]    <= b_r * $signed(up_r[i*COMP_BITS +: COMP_BITS]);
        d_r[i]     <= d_nxt[i];
        mag8_r[i]  <= mag_nxt[i];
        mag9_r[i]  <= mag8_r[i];
        mag10_r[i] <= mag9_r[i];
        nm11_r[i]  <= nm_nxt[i];
        sqv_r[i]   <= nm11_r[i] * nm11_r[i];
        nm12_r[i]  <= nm11_r[i];
        nm13_r[i]  <= nm12_r[i];
      end
      or_r     <= mag_nxt[0] | mag_nxt[1] | mag_nxt[2];
      neg8_r   <= neg_nxt;
      gnz_r    <= gnz_nxt;
      gpos_r   <= gpos_nxt;
      neg9_r   <= neg8_r;
      pos_r    <= pos_nxt;
      zero10_r <= !(|gnz_r);
      neg10_r  <= neg9_r;
      zero11_r <= zero10_r;
      neg11_r  <= neg10_r;
      zero12_r <= zero11_r;
      neg12_r  <= neg11_r;
      sum_r    <= SUM_W'(sqv_r[0]) + SUM_W'(sqv_r[1]) + SUM_W'(sqv_r[2]);
      zero13_r <= zero12_r;
      neg13_r  <= neg12_r;
    end
  end

  // integer square root, one result bit per stage
  logic [SUM_W-1:0] sq_n_r    [SQ_STEPS];
  logic [LEN_W-1:0] sq_root_r [SQ_STEPS];
  logic [RM_W-1:0]  sq_rem_r  [SQ_STEPS];
  logic [NM_W-1:0]  sq_mag_r  [SQ_STEPS][3];
  logic [2:0]       sq_neg_r  [SQ_STEPS];
  logic             sq_zero_r [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    logic [SUM_W-1:0] n_in;
    logic [LEN_W-1:0] root_in, root_nxt;
    logic [RM_W-1:0]  rem_in, rem_nxt;
    logic [RM_W+1:0]  rem_sh, trial;
    logic [NM_W-1:0]  mag_in [3];
    logic [2:0]       neg_in;
    logic             zero_in;

    if (k == 0) begin : g_first
      assign n_in    = sum_r;
      assign root_in = '0;
      assign rem_in  = '0;
      assign mag_in  = nm13_r;
      assign neg_in  = neg13_r;
      assign zero_in = zero13_r;
    end else begin : g_next
      assign n_in    = sq_n_r[k-1];
      assign root_in = sq_root_r[k-1];
      assign rem_in  = sq_rem_r[k-1];
      assign mag_in  = sq_mag_r[k-1];
      assign neg_in  = sq_neg_r[k-1];
      assign zero_in = sq_zero_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_in, n_in[SUM_W-1 -: 2]};
      trial  = (RM_W + 2)'({root_in, 2'b01});
      if (rem_sh >= trial) begin
        rem_nxt  = RM_W'(rem_sh - trial);
        root_nxt = {root_in[LEN_W-2:0], 1'b1};
      end else begin
        rem_nxt  = RM_W'(rem_sh);
        root_nxt = {root_in[LEN_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_n_r[k]    <= {n_in[SUM_W-3:0], 2'b00};
        sq_root_r[k] <= root_nxt;
        sq_rem_r[k]  <= rem_nxt;
        sq_mag_r[k]  <= mag_in;
        sq_neg_r[k]  <= neg_in;
        sq_zero_r[k] <= zero_in;
      end
    end
  end

  // rounded dividend: mag * 2^14 + len / 2
  logic [N_W-1:0]   num_r [3];
  logic [LEN_W-1:0] len_r;
  logic [2:0]       negn_r;
  logic             zeron_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= {1'b0, sq_mag_r[SQ_STEPS-1][i], {COMP_FRAC_BITS{1'b0}}}
                    + N_W'(sq_root_r[SQ_STEPS-1] >> 1);
      end
      len_r   <= sq_root_r[SQ_STEPS-1];
      negn_r  <= sq_neg_r[SQ_STEPS-1];
      zeron_r <= sq_zero_r[SQ_STEPS-1];
    end
  end

  // three restoring dividers, one quotient bit per stage
  logic [LEN_W-1:0] dv_rem_r  [QB][3];
  logic [QB-1:0]    dv_lo_r   [QB][3];
  logic [QB-1:0]    dv_q_r    [QB][3];
  logic [LEN_W-1:0] dv_len_r  [QB];
  logic [2:0]       dv_neg_r  [QB];
  logic             dv_zero_r [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [LEN_W-1:0] rem_in [3];
    logic [QB-1:0]    lo_in  [3];
    logic [QB-1:0]    q_in   [3];
    logic [LEN_W-1:0] len_in;
    logic [2:0]       neg_in;
    logic             zero_in;
    logic [LEN_W:0]   r2 [3];
    logic [LEN_W-1:0] rem_nxt [3];
    logic [QB-1:0]    q_nxt [3];

    if (j == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = LEN_W'(num_r[i][N_W-1:QB]);
        assign lo_in[i]  = num_r[i][QB-1:0];
        assign q_in[i]   = '0;
      end
      assign len_in  = len_r;
      assign neg_in  = negn_r;
      assign zero_in = zeron_r;
    end else begin : g_next
      assign rem_in  = dv_rem_r[j-1];
      assign lo_in   = dv_lo_r[j-1];
      assign q_in    = dv_q_r[j-1];
      assign len_in  = dv_len_r[j-1];
      assign neg_in  = dv_neg_r[j-1];
      assign zero_in = dv_zero_r[j-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i] = {rem_in[i], lo_in[i][QB-1]};
        if (r2[i] >= {1'b0, len_in}) begin
          rem_nxt[i] = LEN_W'(r2[i] - {1'b0, len_in});
          q_nxt[i]   = {q_in[i][QB-2:0], 1'b1};
        end else begin
          rem_nxt[i] = LEN_W'(r2[i]);
          q_nxt[i]   = {q_in[i][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[j][i] <= rem_nxt[i];
          dv_lo_r[j][i]  <= {lo_in[i][QB-2:0], 1'b0};
          dv_q_r[j][i]   <= q_nxt[i];
        end
        dv_len_r[j]  <= len_in;
        dv_neg_r[j]  <= neg_in;
        dv_zero_r[j] <= zero_in;
      end
    end
  end

  // sign and zero-vector handling into the output register
  logic [COMP_BITS-1:0] dir_nxt [3];
  pprd_out_t            out_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero_r[QB-1]) begin
        dir_nxt[i] = '0;
      end else if (dv_neg_r[QB-1][i]) begin
        dir_nxt[i] = -COMP_BITS'(dv_q_r[QB-1][i]);
      end else begin
        dir_nxt[i] = COMP_BITS'(dv_q_r[QB-1][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.dir_x <= dir_nxt[0];
      out_r.dir_y <= dir_nxt[1];
      out_r.dir_z <= dir_nxt[2];
    end
  end

  assign out_data = out_r;

endmodule

// File: hdl/pprd_chk.sv
module pprd_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input pprd_pkg::pprd_out_t out_data
);
  import pprd_pkg::*;

  localparam logic signed [COMP_BITS-1:0] UNIT = COMP_BITS'(1 << COMP_FRAC_BITS);

  // input is held back only while a result is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a blocked result");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> in_valid)
    else $error("stalled request withdrawn");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.dir_x <= UNIT && out_data.dir_x >= -UNIT &&
                   out_data.dir_y <= UNIT && out_data.dir_y >= -UNIT &&
                   out_data.dir_z <= UNIT && out_data.dir_z >= -UNIT))
    else $error("direction component beyond unit length");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

endmodule

bind pinhole_primary_ray_direction pprd_chk u_pprd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
